FILE: hdl/mue_pkg.sv
// ----------------------------------------------------------------------------
// mue_pkg
// types, constants and the character-to-pattern code table for the encoder
// ----------------------------------------------------------------------------
package mue_pkg;

  localparam int unsigned PatW   = 19;   // longest pattern, in timing units
  localparam int unsigned GapW   = 3;    // inter-character gap, in timing units
  localparam int unsigned ShiftW = PatW + GapW;
  localparam int unsigned LenW   = 5;    // holds counts up to ShiftW

  localparam logic [7:0] CharSpace = 8'h20;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic key_level;
    logic last_unit;
  } out_item_t;

  // one code table entry: pattern left-aligned, first unit in the msb
  typedef struct packed {
    logic [LenW-1:0] len;
    logic [PatW-1:0] bits;
  } pat_ent_t;

  // serializer status toward the pipeline control
  typedef struct packed {
    logic busy;
    logic on_last;
  } ser_stat_t;

  function automatic pat_ent_t pat_mk(input logic [LenW-1:0] len,
                                      input logic [PatW-1:0] bits);
    pat_ent_t e;
    e.len  = len;
    e.bits = bits << (LenW'(PatW) - len);
    return e;
  endfunction

  function automatic pat_ent_t pat_lookup(input logic [7:0] c);
    pat_ent_t e;
    case (c)
      8'h61: e = pat_mk(5'd5,  19'b10111);                 // a
      8'h62: e = pat_mk(5'd9,  19'b111010101);             // b
      8'h63: e = pat_mk(5'd11, 19'b11101011101);           // c
      8'h64: e = pat_mk(5'd7,  19'b1110101);               // d
      8'h65: e = pat_mk(5'd1,  19'b1);                     // e
      8'h66: e = pat_mk(5'd9,  19'b101011101);             // f
      8'h67: e = pat_mk(5'd9,  19'b111011101);             // g
      8'h68: e = pat_mk(5'd7,  19'b1010101);               // h
      8'h69: e = pat_mk(5'd3,  19'b101);                   // i
      8'h6a: e = pat_mk(5'd13, 19'b1011101110111);         // j
      8'h6b: e = pat_mk(5'd9,  19'b111010111);             // k
      8'h6c: e = pat_mk(5'd9,  19'b101110101);             // l
      8'h6d: e = pat_mk(5'd7,  19'b1110111);               // m
      8'h6e: e = pat_mk(5'd5,  19'b11101);                 // n
      8'h6f: e = pat_mk(5'd11, 19'b11101110111);           // o
      8'h70: e = pat_mk(5'd11, 19'b10111011101);           // p
      8'h71: e = pat_mk(5'd13, 19'b1110111010111);         // q
      8'h72: e = pat_mk(5'd7,  19'b1011101);               // r
      8'h73: e = pat_mk(5'd5,  19'b10101);                 // s
      8'h74: e = pat_mk(5'd3,  19'b111);                   // t
      8'h75: e = pat_mk(5'd7,  19'b1010111);               // u
      8'h76: e = pat_mk(5'd9,  19'b101010111);             // v
      8'h77: e = pat_mk(5'd9,  19'b101110111);             // w
      8'h78: e = pat_mk(5'd11, 19'b11101010111);           // x
      8'h79: e = pat_mk(5'd13, 19'b1110101110111);         // y
      8'h7a: e = pat_mk(5'd11, 19'b11101110101);           // z
      8'h30: e = pat_mk(5'd19, 19'b1110111011101110111);   // 0
      8'h31: e = pat_mk(5'd17, 19'b10111011101110111);     // 1
      8'h32: e = pat_mk(5'd15, 19'b101011101110111);       // 2
      8'h33: e = pat_mk(5'd13, 19'b1010101110111);         // 3
      8'h34: e = pat_mk(5'd11, 19'b10101010111);           // 4
      8'h35: e = pat_mk(5'd9,  19'b101010101);             // 5
      8'h36: e = pat_mk(5'd11, 19'b11101010101);           // 6
      8'h37: e = pat_mk(5'd13, 19'b1110111010101);         // 7
      8'h38: e = pat_mk(5'd15, 19'b111011101110101);       // 8
      8'h39: e = pat_mk(5'd17, 19'b11101110111011101);     // 9
      8'h2e: e = pat_mk(5'd17, 19'b10111010111010111);     // period
      8'h2c: e = pat_mk(5'd19, 19'b1110111010101110111);   // comma
      8'h3a: e = pat_mk(5'd17, 19'b11101110111010101);     // colon
      8'h3f: e = pat_mk(5'd15, 19'b101011101110101);       // question mark
      8'h27: e = pat_mk(5'd19, 19'b1011101110111011101);   // apostrophe
      8'h2d: e = pat_mk(5'd15, 19'b111010101010111);       // hyphen
      8'h2b: e = pat_mk(5'd13, 19'b1011101011101);         // plus
      8'h3d: e = pat_mk(5'd13, 19'b1110101010111);         // equals
      default: e = pat_mk(5'd5, 19'b00000);                // space, unknown
    endcase
    return e;
  endfunction

endpackage

FILE: hdl/mue_pat_rom.sv
// ----------------------------------------------------------------------------
// mue_pat_rom
// code table rom with registered read
// ----------------------------------------------------------------------------
module mue_pat_rom (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [7:0]        rd_addr,
  output mue_pkg::pat_ent_t rd_data
);
  import mue_pkg::*;

  pat_ent_t rd_data_r;

  // read data holds while no new read is issued
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= pat_lookup(rd_addr);
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hdl/mue_serializer.sv
// ----------------------------------------------------------------------------
// mue_serializer
// shifts out one character's keying pattern, one timing unit per transaction
// ----------------------------------------------------------------------------
module mue_serializer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  logic               gap,
  input  mue_pkg::pat_ent_t  ent,
  input  logic               out_stall,
  output mue_pkg::ser_stat_t stat,
  output mue_pkg::out_item_t out_data
);
  import mue_pkg::*;

  logic              vld_r, vld_nxt;
  logic [LenW-1:0]   cnt_r, cnt_nxt;
  logic [ShiftW-1:0] shift_r, shift_nxt;
  logic              take;

  assign take = vld_r && !out_stall;

  always_comb begin
    vld_nxt   = vld_r;
    cnt_nxt   = cnt_r;
    shift_nxt = shift_r;
    if (take) begin
      shift_nxt = {shift_r[ShiftW-2:0], 1'b0};
      cnt_nxt   = cnt_r - LenW'(1);
      if (cnt_r == LenW'(1)) begin
        vld_nxt = 1'b0;
      end
    end
    if (load) begin
      vld_nxt = 1'b1;
      if (gap) begin
        // three off units lead the pattern
        shift_nxt = {{GapW{1'b0}}, ent.bits};
        cnt_nxt   = ent.len + LenW'(GapW);
      end else begin
        shift_nxt = {ent.bits, {GapW{1'b0}}};
        cnt_nxt   = ent.len;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r   <= cnt_nxt;
    shift_r <= shift_nxt;
  end

  assign stat.busy          = vld_r;
  assign stat.on_last       = vld_r && (cnt_r == LenW'(1));
  assign out_data.key_level = shift_r[ShiftW-1];
  assign out_data.last_unit = (cnt_r == LenW'(1));

endmodule

FILE: hdl/morse_unit_encoder.sv
// ----------------------------------------------------------------------------
// morse_unit_encoder
// international morse encoder: one character in, keying units out
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake             payload
//   in_      input      in_valid / in_stall   in_item_t  {char_code, end_of_text}
//   out_     output     out_valid / out_stall out_item_t {key_level, last_unit}
//
// one timing unit leaves per cycle unless out_stall holds it, so a character is 1 to 22
// units long (pattern length, plus a three-unit gap between non-space characters of one
// text); the output serializer sets the rate
// a character is looked up in the code table rom (registered read) while the
// previous one is still shifting out, so units follow without a bubble
// reset clears the pipeline valids and the previous-character flag
// out_stall freezes the serializer; in_stall rises when a full rom stage cannot load
//
module morse_unit_encoder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  mue_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output mue_pkg::out_item_t out_data
);
  import mue_pkg::*;

  // pipeline control
  logic      in_acc;
  logic      lk_vld_r, lk_vld_nxt;   // rom stage holds a looked-up character
  logic      gap_r;                  // that character gets a leading gap
  logic      prev_nonspace_r, prev_nonspace_nxt;
  logic      is_space;
  logic      ser_load;
  logic      ser_done;
  pat_ent_t  rom_data;
  ser_stat_t ser_stat;

  assign is_space = (in_data.char_code == CharSpace);
  assign in_acc   = in_valid && !in_stall;

  // serializer frees up on the transaction of its last unit
  assign ser_done = ser_stat.on_last && !out_stall;
  assign ser_load = lk_vld_r && (!ser_stat.busy || ser_done);
  assign in_stall = lk_vld_r && !ser_load;

  always_comb begin
    lk_vld_nxt = lk_vld_r;
    if (ser_load) begin
      lk_vld_nxt = 1'b0;
    end
    if (in_acc) begin
      lk_vld_nxt = 1'b1;
    end
  end

  // gap only between two non-space characters of one text
  always_comb begin
    prev_nonspace_nxt = prev_nonspace_r;
    if (in_acc) begin
      prev_nonspace_nxt = !is_space && !in_data.end_of_text;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lk_vld_r        <= 1'b0;
      prev_nonspace_r <= 1'b0;
    end else begin
      lk_vld_r        <= lk_vld_nxt;
      prev_nonspace_r <= prev_nonspace_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      gap_r <= prev_nonspace_r && !is_space;
    end
  end

  // code table lookup, issued with the input transaction
  mue_pat_rom u_rom (
    .clk     (clk),
    .rd_en   (in_acc),
    .rd_addr (in_data.char_code),
    .rd_data (rom_data)
  );

  // unit-by-unit output
  mue_serializer u_ser (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (ser_load),
    .gap       (gap_r),
    .ent       (rom_data),
    .out_stall (out_stall),
    .stat      (ser_stat),
    .out_data  (out_data)
  );

  assign out_valid = ser_stat.busy;

endmodule

FILE: dv/mue_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mue_checker
// watches both channels of the morse encoder, predicts the keying units of
// every accepted character and compares each out transaction in order
// ----------------------------------------------------------------------------
module mue_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  mue_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  mue_pkg::out_item_t out_data,
  output int                 n_fail,
  output int                 n_pending
);
  import mue_pkg::*;

  out_item_t units_q[$];
  logic      prev_nonspace = 1'b0;
  int        fail_cnt      = 0;

  // dot/dash pattern, one character per timing unit
  function automatic string morse_pattern(input logic [7:0] c);
    case (c)
      "a": return "10111";
      "b": return "111010101";
      "c": return "11101011101";
      "d": return "1110101";
      "e": return "1";
      "f": return "101011101";
      "g": return "111011101";
      "h": return "1010101";
      "i": return "101";
      "j": return "1011101110111";
      "k": return "111010111";
      "l": return "101110101";
      "m": return "1110111";
      "n": return "11101";
      "o": return "11101110111";
      "p": return "10111011101";
      "q": return "1110111010111";
      "r": return "1011101";
      "s": return "10101";
      "t": return "111";
      "u": return "1010111";
      "v": return "101010111";
      "w": return "101110111";
      "x": return "11101010111";
      "y": return "1110101110111";
      "z": return "11101110101";
      "0": return "1110111011101110111";
      "1": return "10111011101110111";
      "2": return "101011101110111";
      "3": return "1010101110111";
      "4": return "10101010111";
      "5": return "101010101";
      "6": return "11101010101";
      "7": return "1110111010101";
      "8": return "111011101110101";
      "9": return "11101110111011101";
      ".": return "10111010111010111";
      ",": return "1110111010101110111";
      ":": return "11101110111010101";
      "?": return "101011101110101";
      "'": return "1011101110111011101";
      "-": return "111010101010111";
      "+": return "1011101011101";
      "=": return "1110101010111";
      default: return "00000";
    endcase
  endfunction

  function automatic void queue_char(input in_item_t item);
    string     pat;
    out_item_t u;
    logic      is_space;
    is_space = (item.char_code == CharSpace);
    pat      = morse_pattern(item.char_code);
    u.last_unit = 1'b0;
    if (prev_nonspace && !is_space) begin
      u.key_level = 1'b0;
      repeat (GapW) units_q.push_back(u);
    end
    for (int k = 0; k < pat.len(); k++) begin
      u.key_level = (pat[k] == "1");
      units_q.push_back(u);
    end
    units_q[units_q.size() - 1].last_unit = 1'b1;
    prev_nonspace = !is_space && !item.end_of_text;
  endfunction

  always @(posedge clk) begin
    out_item_t got;
    out_item_t want;
    if (!rst_n) begin
      units_q.delete();
      prev_nonspace = 1'b0;
    end else begin
      if (in_valid && !in_stall) queue_char(in_data);
      if (out_valid && !out_stall) begin
        got = out_data;
        if (units_q.size() == 0) begin
          fail_cnt++;
          $error("unexpected out transaction: key_level %0b last_unit %0b",
                 got.key_level, got.last_unit);
        end else begin
          want = units_q.pop_front();
          if (got.key_level !== want.key_level) begin
            fail_cnt++;
            $error("key_level mismatch: expected %0b, actual %0b",
                   want.key_level, got.key_level);
          end
          if (got.last_unit !== want.last_unit) begin
            fail_cnt++;
            $error("last_unit mismatch: expected %0b, actual %0b",
                   want.last_unit, got.last_unit);
          end
        end
      end
    end
    n_fail    <= fail_cnt;
    n_pending <= units_q.size();
  end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// morse encoder testbench: directed characters, then random texts under
// four idling phases, with a checker comparing every keying unit
// ----------------------------------------------------------------------------
module tb;
  import mue_pkg::*;

  // every character that has a code; the rest of the byte range is unknown
  localparam string CodedChars = "abcdefghijklmnopqrstuvwxyz0123456789.,:?'-+=";
  localparam int    PhaseItems = 48;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  int unsigned idle_pct  = 0;   // sender idle chance per cycle, percent
  int unsigned stall_pct = 0;   // receiver stall chance per cycle, percent
  int          n_fail;
  int          n_pending;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  morse_unit_encoder u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  mue_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .n_fail    (n_fail),
    .n_pending (n_pending)
  );

  // receiver side: random stall, redrawn every cycle
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // one input transaction; idle cycles are decided before valid goes up,
  // so valid never looks at stall and the payload holds while stalled
  task automatic send_char(input logic [7:0] code, input logic eot);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid             <= 1'b1;
    in_data.char_code    <= code;
    in_data.end_of_text  <= eot;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // mostly coded characters, some spaces, some arbitrary bytes
  // (upper case, control bytes, zero and the top half all land here)
  function automatic logic [7:0] pick_char();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return CodedChars[$urandom_range(0, CodedChars.len() - 1)];
    if (roll < 85) return CharSpace;
    return 8'($urandom_range(0, 255));
  endfunction

  initial begin
    int sent;
    int text_len;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: shortest and longest patterns, gap rules, unknown bytes
    send_char("e", 1'b0);           // one unit, first of text so no gap
    send_char("0", 1'b0);           // longest pattern plus gap
    send_char(",", 1'b0);
    send_char("'", 1'b0);
    send_char(CharSpace, 1'b0);     // space never gets a gap, clears history
    send_char("a", 1'b0);           // no gap right after a space
    send_char(8'h00, 1'b0);         // zero byte is just an unknown char
    send_char("Z", 1'b0);           // upper case: silent but still non-space
    send_char(8'hff, 1'b1);         // gap before it, end of text after it
    send_char("t", 1'b0);           // fresh text, no gap
    send_char(CharSpace, 1'b0);
    send_char(CharSpace, 1'b0);     // back-to-back spaces
    send_char(".", 1'b1);
    send_char("x", 1'b1);           // single-char text
    send_char("?", 1'b0);
    send_char("-", 1'b0);
    send_char("+", 1'b0);
    send_char("=", 1'b0);
    send_char(":", 1'b0);
    send_char(CharSpace, 1'b1);     // text ending in a space
    send_char("9", 1'b0);
    send_char(8'h80, 1'b0);
    send_char(8'h7f, 1'b1);

    // random texts; phase 0 runs with no idling at all
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct <= 0;  stall_pct <= 0;  end
        1: begin idle_pct <= 45; stall_pct <= 0;  end
        2: begin idle_pct <= 0;  stall_pct <= 45; end
        default: begin idle_pct <= 38; stall_pct <= 38; end
      endcase
      sent = 0;
      while (sent < PhaseItems) begin
        text_len = $urandom_range(1, 8);
        for (int k = 0; k < text_len; k++) begin
          send_char(pick_char(), k == text_len - 1);
          sent++;
        end
      end
    end
    in_valid <= 1'b0;

    // let the checker count the last accepted character first
    @(posedge clk);

    // drain: every predicted unit must come out, then watch for extras
    while (n_pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);

    if (n_fail == 0 && n_pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #3_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
